/* hw/rtl/sbnrp_pkg.sv */
package sbnrp_pkg;

    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 5;
    localparam int OUT_IDX_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 5;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_VARIATION_COUNT = 1'd0;
    localparam t_cfg_idx CFG_NO_REPEAT_MODE  = 1'd1;

    localparam int STATE_W = 4;
    typedef logic [STATE_W-1:0] t_state;
    localparam t_state S_IDLE   = 4'd0;
    localparam t_state S_DECIDE = 4'd1;
    localparam t_state S_POP    = 4'd2;
    localparam t_state S_FILL   = 4'd3;
    localparam t_state S_MUL    = 4'd4;
    localparam t_state S_RD     = 4'd5;
    localparam t_state S_WI     = 4'd6;
    localparam t_state S_WJ     = 4'd7;
    localparam t_state S_TOPRD  = 4'd8;
    localparam t_state S_TOP    = 4'd9;
    localparam t_state S_DONE   = 4'd10;

endpackage

/* hw/rtl/shuffle_bag_no_repeat_picker_unit.sv */
// Variation picker with an optional no-repeat shuffle bag.
// Request channel: i_req_valid / o_req_stall carry i_random_word. A request
// is taken only while the unit is idle; o_req_stall is high while one is in
// progress. Response channel: o_rsp_valid / i_rsp_stall carry o_chosen_index
// and o_bag_refilled, one response per request, held stable while stalled.
// Configuration: i_cfg_we writes register i_cfg_index (0 variation count,
// 1 no-repeat mode) and empties the bag; write only while the unit is idle.
// Steps: a plain pick or a trivial count goes from the decide state straight to
// the response, a pop from a non-empty bag adds a pop state. A refill with an
// effective count n runs the decide state, loads the n bag entries through the
// single write port, performs the n-1 Fisher-Yates swaps (each with one shared
// 32-bit multiply, a two-address registered read and two writes), reads and
// checks the top entry and loads the response.
// The unit returns to idle, ready for the next request, as a response enters
// the output register, so a stalled response holds the unit only once the next
// result is ready. Reset clears the state, configuration and output-valid
// registers, empties the bag and forgets the last pick; the bag memory itself
// needs no clearing.
module shuffle_bag_no_repeat_picker_unit #(
    parameter int MAX_VARIATIONS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    output logic                              o_req_stall,
    input  logic [sbnrp_pkg::WORD_W-1:0]      i_random_word,
    output logic                              o_rsp_valid,
    input  logic                              i_rsp_stall,
    output logic [sbnrp_pkg::OUT_IDX_W-1:0]   o_chosen_index,
    output logic                              o_bag_refilled,
    input  logic                              i_cfg_we,
    input  logic [sbnrp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbnrp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sbnrp_pkg::*;

    localparam int N_MAX = (MAX_VARIATIONS < 31) ? MAX_VARIATIONS : 31;
    localparam int IDX_W = $clog2(N_MAX);
    localparam int CNT_W = $clog2(N_MAX + 1);
    localparam int PROD_W = WORD_W + CNT_W;

    function automatic logic [WORD_W-1:0] next_word(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    logic [IDX_W-1:0] r_mem [N_MAX];
    logic [IDX_W-1:0] r_rd_a, r_rd_b;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_wdata, mem_ra, mem_rb;

    t_state           r_state, n_state;
    logic [COUNT_W-1:0] r_count;
    logic             r_mode;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_last, n_last;
    logic             r_last_valid, n_last_valid;
    logic [WORD_W-1:0] r_w, n_w;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_pick, n_pick;
    logic             r_refilled, n_refilled;
    logic             r_out_valid, n_out_valid;
    logic [OUT_IDX_W-1:0] r_out_idx, n_out_idx;
    logic             r_out_refilled, n_out_refilled;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] mul_b;
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0] mul_hi;
    logic [IDX_W-1:0] top_addr;

    always_comb begin
        if (32'(r_count) > 32'(MAX_VARIATIONS)) begin
            n_eff = CNT_W'(N_MAX);
        end else begin
            n_eff = CNT_W'(r_count);
        end
    end

    assign top_addr = IDX_W'(n_eff - CNT_W'(1));
    assign mul_b    = (r_state == S_DECIDE) ? n_eff : CNT_W'(r_i) + CNT_W'(1);
    assign prod     = PROD_W'(r_w) * PROD_W'(mul_b);
    assign mul_hi   = IDX_W'(prod[WORD_W +: CNT_W]);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_mem[mem_ra];
        r_rd_b <= r_mem[mem_rb];
    end

    always_comb begin
        n_state        = r_state;
        n_fill         = r_fill;
        n_last         = r_last;
        n_last_valid   = r_last_valid;
        n_w            = r_w;
        n_i            = r_i;
        n_j            = r_j;
        n_k            = r_k;
        n_pick         = r_pick;
        n_refilled     = r_refilled;
        n_out_valid    = r_out_valid;
        n_out_idx      = r_out_idx;
        n_out_refilled = r_out_refilled;
        mem_we         = 1'b0;
        mem_waddr      = r_k;
        mem_wdata      = r_k;
        mem_ra         = IDX_W'(r_fill - CNT_W'(1));
        mem_rb         = r_j;

        if (r_out_valid && !i_rsp_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_w        = i_random_word;
                    n_refilled = 1'b0;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (n_eff <= CNT_W'(1)) begin
                    n_pick  = '0;
                    n_state = S_DONE;
                end else if (!r_mode) begin
                    n_pick  = mul_hi;
                    n_state = S_DONE;
                end else if (r_fill == '0 || r_fill > n_eff) begin
                    n_refilled = 1'b1;
                    n_k        = '0;
                    n_state    = S_FILL;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_pick       = r_rd_a;
                n_fill       = r_fill - CNT_W'(1);
                n_last       = r_rd_a;
                n_last_valid = 1'b1;
                n_state      = S_DONE;
            end
            S_FILL: begin
                mem_we = 1'b1;
                n_k    = r_k + IDX_W'(1);
                if (r_k == top_addr) begin
                    n_i     = top_addr;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_j     = mul_hi;
                n_state = S_RD;
            end
            S_RD: begin
                mem_ra  = r_i;
                mem_rb  = r_j;
                n_state = S_WI;
            end
            S_WI: begin
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_rd_b;
                mem_ra    = r_i;
                mem_rb    = r_j;
                n_state   = S_WJ;
            end
            S_WJ: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_rd_a;
                n_w       = next_word(r_w);
                if (r_i == IDX_W'(1)) begin
                    n_state = S_TOPRD;
                end else begin
                    n_i     = r_i - IDX_W'(1);
                    n_state = S_MUL;
                end
            end
            S_TOPRD: begin
                mem_ra  = top_addr;
                mem_rb  = '0;
                n_state = S_TOP;
            end
            S_TOP: begin
                if (r_last_valid && r_rd_a == r_last) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = r_rd_a;
                    n_pick    = r_rd_b;
                    n_last    = r_rd_b;
                end else begin
                    n_pick = r_rd_a;
                    n_last = r_rd_a;
                end
                n_last_valid = 1'b1;
                n_fill       = n_eff - CNT_W'(1);
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_rsp_stall) begin
                    n_out_valid    = 1'b1;
                    n_out_idx      = OUT_IDX_W'(r_pick);
                    n_out_refilled = r_refilled;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_mode       <= 1'b0;
            r_fill       <= '0;
            r_last       <= '0;
            r_last_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
            if (i_cfg_we && (i_cfg_index == CFG_VARIATION_COUNT ||
                             i_cfg_index == CFG_NO_REPEAT_MODE)) begin
                case (i_cfg_index)
                    CFG_VARIATION_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_NO_REPEAT_MODE:  r_mode  <= i_cfg_data[0];
                    default:             r_mode  <= r_mode;
                endcase
                r_fill       <= '0;
                r_last_valid <= 1'b0;
            end else begin
                r_fill       <= n_fill;
                r_last_valid <= n_last_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w            <= n_w;
        r_i            <= n_i;
        r_j            <= n_j;
        r_k            <= n_k;
        r_pick         <= n_pick;
        r_refilled     <= n_refilled;
        r_out_idx      <= n_out_idx;
        r_out_refilled <= n_out_refilled;
    end

    assign o_req_stall    = (r_state != S_IDLE);
    assign o_rsp_valid    = r_out_valid;
    assign o_chosen_index = r_out_idx;
    assign o_bag_refilled = r_out_refilled;

endmodule

/* bench/variation_pick_checker.sv */
`timescale 1ns / 1ps

module variation_pick_checker #(
    parameter int MAX_VARIATIONS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_stall,
    input  logic [sbnrp_pkg::WORD_W-1:0]     i_random_word,
    input  logic                             i_rsp_valid,
    input  logic                             i_rsp_stall,
    input  logic [sbnrp_pkg::OUT_IDX_W-1:0]  i_chosen_index,
    input  logic                             i_bag_refilled,
    input  logic                             i_cfg_we,
    input  logic [sbnrp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbnrp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                               o_failures,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_refills
);
    import sbnrp_pkg::*;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] index;
        logic                 refilled;
    } t_pick;

    logic [COUNT_W-1:0]   var_count;
    logic                 no_repeat;
    logic [OUT_IDX_W-1:0] bag [MAX_VARIATIONS];
    int unsigned          bag_fill;
    logic [OUT_IDX_W-1:0] last_pick;
    logic                 last_pick_valid;

    t_pick expected_picks[$];
    t_pick exp_pick;
    int    err_count;
    int    checked_count;
    int    refill_count;

    function automatic logic [WORD_W-1:0] xorshift_next(input logic [WORD_W-1:0] x);
        x ^= x << 13;
        x ^= x >> 17;
        x ^= x << 5;
        return x;
    endfunction

    function automatic int unsigned scale_word(input logic [WORD_W-1:0] w,
                                               input int unsigned n);
        logic [63:0] prod;
        prod = 64'(w) * 64'(n);
        return int'(prod[63:32]);
    endfunction

    function automatic void shuffle_refill(input int unsigned n, input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0]    w;
        int unsigned          j;
        logic [OUT_IDX_W-1:0] t;
        for (int unsigned i = 0; i < n; i++) begin
            bag[i] = OUT_IDX_W'(i);
        end
        w = word;
        for (int unsigned i = n - 1; i > 0; i--) begin
            j = scale_word(w, i + 1);
            t = bag[i];
            bag[i] = bag[j];
            bag[j] = t;
            w = xorshift_next(w);
        end
        // keep the first pick of a new bag away from the previous pick
        if (last_pick_valid && bag[n-1] == last_pick) begin
            t = bag[n-1];
            bag[n-1] = bag[0];
            bag[0] = t;
        end
        bag_fill = n;
    endfunction

    function automatic t_pick predict_pick(input logic [WORD_W-1:0] word);
        t_pick       res;
        int unsigned n;
        res = '0;
        n = (var_count > MAX_VARIATIONS) ? MAX_VARIATIONS : var_count;
        if (n > 1) begin
            if (!no_repeat) begin
                res.index = OUT_IDX_W'(scale_word(word, n));
            end else begin
                if (bag_fill == 0 || bag_fill > n) begin
                    shuffle_refill(n, word);
                    res.refilled = 1'b1;
                end
                bag_fill--;
                res.index = bag[bag_fill];
                last_pick = res.index;
                last_pick_valid = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            var_count = '0;
            no_repeat = 1'b0;
            bag_fill = 0;
            last_pick = '0;
            last_pick_valid = 1'b0;
            expected_picks.delete();
            err_count = 0;
            checked_count = 0;
            refill_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VARIATION_COUNT: var_count = i_cfg_data[COUNT_W-1:0];
                    CFG_NO_REPEAT_MODE:  no_repeat = i_cfg_data[0];
                    default: ;
                endcase
                bag_fill = 0;
                last_pick_valid = 1'b0;
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_picks.size() == 0) begin
                    $display("%0t: response with no request pending: index %0d refilled %0b",
                             $time, i_chosen_index, i_bag_refilled);
                    err_count++;
                end else begin
                    exp_pick = expected_picks.pop_front();
                    if (i_chosen_index !== exp_pick.index) begin
                        $display("%0t: chosen_index expected %0d got %0d",
                                 $time, exp_pick.index, i_chosen_index);
                        err_count++;
                    end
                    if (i_bag_refilled !== exp_pick.refilled) begin
                        $display("%0t: bag_refilled expected %0b got %0b",
                                 $time, exp_pick.refilled, i_bag_refilled);
                        err_count++;
                    end
                    checked_count++;
                    if (exp_pick.refilled) begin
                        refill_count++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                expected_picks.push_back(predict_pick(i_random_word));
            end
        end
        o_failures <= err_count;
        o_pending <= expected_picks.size();
        o_checked <= checked_count;
        o_refills <= refill_count;
    end

endmodule

/* bench/shuffle_bag_no_repeat_picker_unit_test.sv */
`timescale 1ns / 1ps

module shuffle_bag_no_repeat_picker_unit_test;
    import sbnrp_pkg::*;

    localparam int MAX_VARIATIONS = 16;
    localparam int RANDOM_ITEMS   = 1300;

    localparam int STALL_NONE   = 0;
    localparam int STALL_LIGHT  = 1;
    localparam int STALL_HEAVY  = 2;
    localparam int STALL_PERIOD = 3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_req_valid = 1'b0;
    logic                  o_req_stall;
    logic [WORD_W-1:0]     i_random_word = '0;
    logic                  o_rsp_valid;
    logic                  i_rsp_stall = 1'b0;
    logic [OUT_IDX_W-1:0]  o_chosen_index;
    logic                  o_bag_refilled;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int failures;
    int pending;
    int checked;
    int refills;

    int sent = 0;
    int settings = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_style = STALL_NONE;

    shuffle_bag_no_repeat_picker_unit #(
        .MAX_VARIATIONS(MAX_VARIATIONS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req_valid),
        .o_req_stall    (o_req_stall),
        .i_random_word  (i_random_word),
        .o_rsp_valid    (o_rsp_valid),
        .i_rsp_stall    (i_rsp_stall),
        .o_chosen_index (o_chosen_index),
        .o_bag_refilled (o_bag_refilled),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    variation_pick_checker #(
        .MAX_VARIATIONS(MAX_VARIATIONS)
    ) pick_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req_valid),
        .i_req_stall    (o_req_stall),
        .i_random_word  (i_random_word),
        .i_rsp_valid    (o_rsp_valid),
        .i_rsp_stall    (i_rsp_stall),
        .i_chosen_index (o_chosen_index),
        .i_bag_refilled (o_bag_refilled),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_failures     (failures),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_refills      (refills)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(STALL_NONE, STALL_PERIOD);
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        case (stall_style)
            STALL_NONE:  i_rsp_stall <= 1'b0;
            STALL_LIGHT: i_rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     i_rsp_stall <= ((stall_left % 7) < 4);
        endcase
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_count();
        case ($urandom_range(0, 9))
            6:       return CFG_DATA_W'(MAX_VARIATIONS);
            7:       return CFG_DATA_W'($urandom_range(MAX_VARIATIONS + 1, 31));
            8:       return CFG_DATA_W'($urandom_range(0, 1));
            9:       return CFG_DATA_W'($urandom_range(9, MAX_VARIATIONS - 1));
            default: return CFG_DATA_W'($urandom_range(2, 8));
        endcase
    endfunction

    task automatic send_request(input logic [WORD_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_req_valid <= 1'b1;
        i_random_word <= word;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        burst_left--;
        sent++;
    endtask

    task automatic wait_idle();
        i_req_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic wr_count, input logic [CFG_DATA_W-1:0] count_data,
                            input logic wr_mode, input logic [CFG_DATA_W-1:0] mode_data);
        wait_idle();
        if (wr_count) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= CFG_VARIATION_COUNT;
            i_cfg_data <= count_data;
            @(posedge i_clk);
        end
        if (wr_mode) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= CFG_NO_REPEAT_MODE;
            i_cfg_data <= mode_data;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [CFG_DATA_W-1:0] mode_data;
        int                    sel;
        int                    len;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // count 0 straight out of reset
        send_request('1);

        set_regs(1'b1, 5'd1, 1'b1, 5'd1);
        send_request('1);
        send_request('0);

        // count above the maximum, plain mode
        set_regs(1'b1, 5'd17, 1'b1, 5'd0);
        send_request('0);
        send_request('1);
        send_request(32'h8000_0000);

        set_regs(1'b1, 5'd31, 1'b1, 5'd1);
        send_request('0);
        send_request('1);
        send_request(rand_word());
        send_request(rand_word());

        // two entries: refills back to back exercise the last-pick swap
        set_regs(1'b1, 5'd2, 1'b1, 5'd3);
        repeat (6) send_request(rand_word());

        set_regs(1'b1, 5'd16, 1'b0, 5'd0);
        send_request('1);
        send_request('0);
        repeat (3) send_request(rand_word());

        // drop the half-used bag by switching to plain mode
        set_regs(1'b0, 5'd0, 1'b1, 5'd2);
        send_request('1);
        send_request('0);
        send_request(rand_word());

        while (sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 7);
            mode_data = CFG_DATA_W'($urandom_range(0, 31));
            mode_data[0] = ($urandom_range(0, 3) != 0);
            set_regs(sel != 0, rand_count(), sel != 1, mode_data);
            len = $urandom_range(1, 40);
            repeat (len) send_request(rand_word());
        end

        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("tb: %0d requests over %0d register settings, %0d responses checked",
                 sent, settings, checked);
        $display("tb: %0d responses came from a freshly shuffled bag", refills);
        if (failures == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
